FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, reset-gated on an active-low reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TVP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define TVP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/tvp_pkg.sv
// ---------------------------------------------------------------------------
// tvp_pkg
// constants, codes and types of the trapezoidal velocity profile block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  localparam longint unsigned ONE_Q     = 64'd1 << FRAC_BITS;
  localparam longint unsigned FLOOR_RAW = (ONE_Q + 64'd500) / 64'd1000;
  localparam logic [31:0] FLOOR_Q = (FLOOR_RAW != 0) ? 32'(FLOOR_RAW) : 32'd1;
  localparam logic [31:0] TOL_Q   = 32'((ONE_Q + 64'd500000) / 64'd1000000);
  localparam int          TICK_SHIFT = FRAC_BITS - 2;
  localparam logic [47:0] TICK_Q  = 48'd1 << TICK_SHIFT;

  localparam logic [31:0] FEED_RST  = 32'd39321600;
  localparam logic [31:0] ACCEL_RST = 32'd6553600;
  localparam logic [31:0] DECEL_RST = 32'd6553600;
  localparam logic [31:0] VLIM_RST  = 32'd655360;

  // register indexes
  localparam logic [1:0] REG_FEED  = 2'd0;
  localparam logic [1:0] REG_ACCEL = 2'd1;
  localparam logic [1:0] REG_DECEL = 2'd2;
  localparam logic [1:0] REG_VLIM  = 2'd3;

  // commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // phases
  localparam logic [1:0] PH_ACC   = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DEC   = 2'd2;

  // shared unit operations
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

endpackage

FILE: rtl/tvp_if.sv
// ---------------------------------------------------------------------------
// tvp channel interfaces
// valid/ready channels for command items and velocity samples
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tvp_in_if;
  import tvp_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DATA_W-1:0] move_distance;
  modport source (output valid, output cmd, output move_distance, input ready);
  modport sink   (input valid, input cmd, input move_distance, output ready);
endinterface

interface tvp_out_if;
  import tvp_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] velocity_mm_per_min;
  logic [1:0]        phase;
  logic [DATA_W-1:0] sample_index;
  logic              last_sample;
  modport source (output valid, output velocity_mm_per_min, output phase,
                  output sample_index, output last_sample, input ready);
  modport sink   (input valid, input velocity_mm_per_min, input phase,
                  input sample_index, input last_sample, output ready);
endinterface

FILE: rtl/tvp_alu.sv
// ---------------------------------------------------------------------------
// tvp_alu
// shared unit: 32x32 multiply, bit-serial rounding divide (64/33)
// and digit-serial integer square root (64 -> 32)
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvp_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  tvp_pkg::alu_req_t req,
  input  logic [63:0]       opa,
  input  logic [32:0]       opb,
  output logic              done,
  output logic [63:0]       res
);
  import tvp_pkg::*;

  logic        busy_r, busy_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] x_r, x_nxt;
  logic [32:0] b_r, b_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [63:0] res_r, res_nxt;
  logic        done_r, done_nxt;

  logic [33:0] div_rs;
  logic        div_ge;
  logic        div_up;
  logic [34:0] sq_rs;
  logic [34:0] sq_trial;
  logic        sq_ge;
  logic [63:0] prod;

  assign div_rs   = {rem_r[32:0], x_r[63]};
  assign div_ge   = div_rs >= {1'b0, b_r};
  assign div_up   = {rem_r[32:0], 1'b0} >= {1'b0, b_r};
  assign sq_rs    = {rem_r[32:0], x_r[63:62]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = sq_rs >= sq_trial;
  assign prod     = 64'(x_r[31:0]) * 64'(b_r[31:0]);

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      x_nxt    = opa;
      b_nxt    = opb;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = (req.op == OP_SQRT) ? 7'd32 : 7'd64;
    end else if (busy_r) begin
      unique case (op_r)
        OP_DIV: begin
          if (cnt_r != 7'd0) begin
            rem_nxt = div_ge ? 35'(div_rs - {1'b0, b_r}) : 35'(div_rs);
            x_nxt   = {x_r[62:0], div_ge};
            cnt_nxt = cnt_r - 7'd1;
          end else begin
            // round to nearest, ties up
            res_nxt  = x_r + 64'(div_up);
            done_nxt = 1'b1;
            busy_nxt = 1'b0;
          end
        end
        OP_SQRT: begin
          if (cnt_r != 7'd0) begin
            rem_nxt  = sq_ge ? (sq_rs - sq_trial) : sq_rs;
            root_nxt = {root_r[30:0], sq_ge};
            x_nxt    = {x_r[61:0], 2'b00};
            cnt_nxt  = cnt_r - 7'd1;
          end else begin
            res_nxt  = 64'(root_r);
            done_nxt = 1'b1;
            busy_nxt = 1'b0;
          end
        end
        default: begin
          res_nxt  = prod;
          done_nxt = 1'b1;
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    b_r    <= b_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: rtl/trapezoidal_velocity_profile_core.sv
// ---------------------------------------------------------------------------
// trapezoidal_velocity_profile_core
// A start item plans a move (trapezoidal, or triangular when too short) on
// one shared multiply/divide/square-root unit, so no item is taken while
// it runs. Both plans use five bit-serial divides, and the triangular
// path adds a square root. A tick item runs one multiply on the shared
// unit, and its sample is held in an output register, so a new item is
// taken while it waits. Ticks with no move in progress give no sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trapezoidal_velocity_profile_core (
  input  logic                      clk,
  input  logic                      rst_n,
  tvp_in_if.sink                    in_ch,
  tvp_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [tvp_pkg::DATA_W-1:0] cfg_wdata
);
  import tvp_pkg::*;
  `include "assert_macros.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_V    = 4'd1;
  localparam logic [3:0] S_VV   = 4'd2;
  localparam logic [3:0] S_DA   = 4'd3;
  localparam logic [3:0] S_DD   = 4'd4;
  localparam logic [3:0] S_AD   = 4'd5;
  localparam logic [3:0] S_H    = 4'd6;
  localparam logic [3:0] S_P    = 4'd7;
  localparam logic [3:0] S_SQ   = 4'd8;
  localparam logic [3:0] S_TC   = 4'd9;
  localparam logic [3:0] S_TA   = 4'd10;
  localparam logic [3:0] S_TD   = 4'd11;
  localparam logic [3:0] S_TMUL = 4'd12;
  localparam logic [3:0] S_TOUT = 4'd13;

  // feed / 60 rounded: ((feed + 30) >> 2) / 15 by reciprocal multiply
  localparam logic [32:0] DIV60_BIAS  = 33'd30;
  localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;
  localparam int          DIV15_SHIFT = 35;

  logic [31:0] feed_r, accel_r, decel_r, vlim_r;

  logic [3:0]  st_r, st_nxt;
  logic        iss_r, iss_nxt;
  logic        active_r, active_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic        tri_r, tri_nxt;
  logic [31:0] pk_r, pk_nxt;
  logic [31:0] ae_r, ae_nxt;
  logic [31:0] ds_r, ds_nxt;
  logic [31:0] end_r, end_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] d_r, d_nxt;
  logic [31:0] v_r, v_nxt;
  logic [31:0] dist_r, dist_nxt;
  logic [63:0] vv_r, vv_nxt;
  logic [63:0] da_r, da_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] tc_r, tc_nxt;
  logic [31:0] ta_r, ta_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        last_r, last_nxt;
  logic [31:0] mb_r, mb_nxt;

  logic        out_vld_r, out_vld_nxt;
  logic [31:0] out_vel_r, out_vel_nxt;
  logic [1:0]  out_ph_r, out_ph_nxt;
  logic [31:0] out_idx_r, out_idx_nxt;
  logic        out_last_r, out_last_nxt;

  alu_req_t    alu_req;
  logic [63:0] alu_a;
  logic [32:0] alu_b;
  logic        alu_done;
  logic [63:0] alu_res;

  logic        in_xfer;
  logic        out_load;
  logic [31:0] v_q, v_f1, v_l, v_f2;
  logic [63:0] rem_dist;
  logic [47:0] t_w, tol_w, diff_w, sv;
  logic [47:0] vel;
  logic [54:0] vel60;
  logic [31:0] ds_sum, td_sat, end_sum;

  tvp_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_a),
    .opb   (alu_b),
    .done  (alu_done),
    .res   (alu_res)
  );

  assign in_ch.ready = (st_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_r  <= FEED_RST;
      accel_r <= ACCEL_RST;
      decel_r <= DECEL_RST;
      vlim_r  <= VLIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FEED:  feed_r  <= cfg_wdata;
        REG_ACCEL: accel_r <= cfg_wdata;
        REG_DECEL: decel_r <= cfg_wdata;
        default:   vlim_r  <= cfg_wdata;
      endcase
    end
  end

  // operand datapath helpers
  always_comb begin
    v_q  = 32'(alu_res >> DIV15_SHIFT);
    v_f1 = (v_q < FLOOR_Q) ? FLOOR_Q : v_q;
    v_l  = (vlim_r < v_f1) ? vlim_r : v_f1;
    v_f2 = (v_l < FLOOR_Q) ? FLOOR_Q : v_l;
    rem_dist = 64'(dist_r) - da_r - alu_res;
    t_w    = 48'(tick_r) << TICK_SHIFT;
    tol_w  = tri_r ? 48'd0 : 48'(TOL_Q);
    diff_w = t_w - 48'(ds_r);
    // shift by FRAC_BITS with rounding
    sv     = 48'(alu_res >> FRAC_BITS) + 48'(alu_res[FRAC_BITS-1]);
    if (ph_r == PH_ACC) begin
      vel = sv;
    end else if (ph_r == PH_CRUISE) begin
      vel = 48'(pk_r);
    end else begin
      vel = (48'(pk_r) > sv) ? (48'(pk_r) - sv) : 48'd0;
    end
    vel60   = (55'(vel) << 6) - (55'(vel) << 2);
    ds_sum  = ((33'(ta_r) + 33'(tc_r)) > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                         : ta_r + tc_r;
    td_sat  = (alu_res[63:32] != 32'd0) ? 32'hFFFF_FFFF : alu_res[31:0];
    end_sum = ((33'(ds_sum) + 33'(td_sat)) > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                             : ds_sum + td_sat;
  end

  assign out_load = (st_r == S_TOUT) && (!out_vld_r || out_ch.ready);

  always_comb begin
    st_nxt     = st_r;
    iss_nxt    = iss_r;
    active_nxt = active_r;
    tick_nxt   = tick_r;
    tri_nxt    = tri_r;
    pk_nxt     = pk_r;
    ae_nxt     = ae_r;
    ds_nxt     = ds_r;
    end_nxt    = end_r;
    a_nxt      = a_r;
    d_nxt      = d_r;
    v_nxt      = v_r;
    dist_nxt   = dist_r;
    vv_nxt     = vv_r;
    da_nxt     = da_r;
    h_nxt      = h_r;
    tc_nxt     = tc_r;
    ta_nxt     = ta_r;
    ph_nxt     = ph_r;
    last_nxt   = last_r;
    mb_nxt     = mb_r;
    alu_req.op = OP_DIV;
    alu_a      = '0;
    alu_b      = '0;

    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_vel_nxt  = out_vel_r;
    out_ph_nxt   = out_ph_r;
    out_idx_nxt  = out_idx_r;
    out_last_nxt = out_last_r;

    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.cmd == CMD_START) begin
            dist_nxt   = in_ch.move_distance;
            a_nxt      = (accel_r < FLOOR_Q) ? FLOOR_Q : accel_r;
            d_nxt      = (decel_r < FLOOR_Q) ? FLOOR_Q : decel_r;
            active_nxt = 1'b0;
            st_nxt     = S_V;
          end else if (active_r) begin
            if (t_w <= 48'(ae_r) + tol_w) begin
              ph_nxt = PH_ACC;
              mb_nxt = (t_w[47:32] != 16'd0) ? 32'hFFFF_FFFF : t_w[31:0];
            end else if (t_w <= 48'(ds_r) + tol_w) begin
              ph_nxt = PH_CRUISE;
              mb_nxt = '0;
            end else begin
              ph_nxt = PH_DEC;
              mb_nxt = (diff_w[47:32] != 16'd0) ? 32'hFFFF_FFFF : diff_w[31:0];
            end
            last_nxt = (t_w + TICK_Q) > (48'(end_r) + tol_w);
            st_nxt   = S_TMUL;
          end
        end
      end
      S_V: begin
        alu_req.op = OP_MUL;
        alu_a = 64'((33'(feed_r) + DIV60_BIAS) >> 2);
        alu_b = {1'b0, DIV15_MAGIC};
        if (alu_done) begin
          v_nxt  = v_f2;
          pk_nxt = v_f2;
          st_nxt = S_VV;
        end
      end
      S_VV: begin
        alu_req.op = OP_MUL;
        alu_a = 64'(v_r);
        alu_b = 33'(v_r);
        if (alu_done) begin
          vv_nxt = alu_res;
          st_nxt = S_DA;
        end
      end
      S_DA: begin
        alu_req.op = OP_DIV;
        alu_a = vv_r;
        alu_b = {a_r, 1'b0};
        if (alu_done) begin
          da_nxt = alu_res;
          st_nxt = S_DD;
        end
      end
      S_DD: begin
        alu_req.op = OP_DIV;
        alu_a = vv_r;
        alu_b = {d_r, 1'b0};
        if (alu_done) begin
          // no room for a cruise phase
          tri_nxt = (da_r > 64'(dist_r)) || ((64'(dist_r) - da_r) < alu_res);
          tc_nxt  = rem_dist[31:0];
          st_nxt  = tri_nxt ? S_AD : S_TC;
          if (tri_nxt) begin
            tc_nxt = '0;
          end
        end
      end
      S_AD: begin
        alu_req.op = OP_MUL;
        alu_a = 64'(a_r);
        alu_b = 33'(d_r);
        if (alu_done) begin
          vv_nxt = alu_res;
          st_nxt = S_H;
        end
      end
      S_H: begin
        alu_req.op = OP_DIV;
        alu_a = vv_r;
        alu_b = 33'(a_r) + 33'(d_r);
        if (alu_done) begin
          h_nxt  = alu_res[31:0];
          st_nxt = S_P;
        end
      end
      S_P: begin
        alu_req.op = OP_MUL;
        alu_a = 64'(h_r);
        alu_b = 33'(dist_r);
        if (alu_done) begin
          vv_nxt = alu_res;
          st_nxt = S_SQ;
        end
      end
      S_SQ: begin
        alu_req.op = OP_SQRT;
        alu_a = vv_r[63] ? 64'hFFFF_FFFF_FFFF_FFFF : {vv_r[62:0], 1'b0};
        if (alu_done) begin
          pk_nxt = alu_res[31:0];
          st_nxt = S_TA;
        end
      end
      S_TC: begin
        alu_req.op = OP_DIV;
        alu_a = 64'(tc_r) << FRAC_BITS;
        alu_b = 33'(v_r);
        if (alu_done) begin
          tc_nxt = td_sat;
          st_nxt = S_TA;
        end
      end
      S_TA: begin
        alu_req.op = OP_DIV;
        alu_a = 64'(pk_r) << FRAC_BITS;
        alu_b = 33'(a_r);
        if (alu_done) begin
          ta_nxt = td_sat;
          st_nxt = S_TD;
        end
      end
      S_TD: begin
        alu_req.op = OP_DIV;
        alu_a = 64'(pk_r) << FRAC_BITS;
        alu_b = 33'(d_r);
        if (alu_done) begin
          ae_nxt     = ta_r;
          ds_nxt     = ds_sum;
          end_nxt    = end_sum;
          tick_nxt   = '0;
          active_nxt = 1'b1;
          st_nxt     = S_IDLE;
        end
      end
      S_TMUL: begin
        alu_req.op = OP_MUL;
        alu_a = 64'((ph_r == PH_ACC) ? a_r : d_r);
        alu_b = 33'(mb_r);
        if (alu_done) begin
          st_nxt = S_TOUT;
        end
      end
      S_TOUT: begin
        if (out_load) begin
          out_vld_nxt  = 1'b1;
          out_vel_nxt  = (vel60[54:32] != 23'd0) ? 32'hFFFF_FFFF : vel60[31:0];
          out_ph_nxt   = ph_r;
          out_idx_nxt  = tick_r;
          out_last_nxt = last_r;
          if (last_r) begin
            active_nxt = 1'b0;
          end else if (tick_r != 32'hFFFF_FFFF) begin
            tick_nxt = tick_r + 32'd1;
          end
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    // one request per arithmetic step
    alu_req.start = 1'b0;
    if (st_r != S_IDLE && st_r != S_TOUT) begin
      if (!iss_r) begin
        alu_req.start = 1'b1;
        iss_nxt = 1'b1;
      end
      if (alu_done) begin
        iss_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      iss_r     <= 1'b0;
      active_r  <= 1'b0;
      tick_r    <= '0;
      tri_r     <= 1'b0;
      pk_r      <= '0;
      ae_r      <= '0;
      ds_r      <= '0;
      end_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      iss_r     <= iss_nxt;
      active_r  <= active_nxt;
      tick_r    <= tick_nxt;
      tri_r     <= tri_nxt;
      pk_r      <= pk_nxt;
      ae_r      <= ae_nxt;
      ds_r      <= ds_nxt;
      end_r     <= end_nxt;
      out_vld_r <= out_vld_nxt;
    end
    a_r        <= a_nxt;
    d_r        <= d_nxt;
    v_r        <= v_nxt;
    dist_r     <= dist_nxt;
    vv_r       <= vv_nxt;
    da_r       <= da_nxt;
    h_r        <= h_nxt;
    tc_r       <= tc_nxt;
    ta_r       <= ta_nxt;
    ph_r       <= ph_nxt;
    last_r     <= last_nxt;
    mb_r       <= mb_nxt;
    out_vel_r  <= out_vel_nxt;
    out_ph_r   <= out_ph_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid               = out_vld_r;
  assign out_ch.velocity_mm_per_min = out_vel_r;
  assign out_ch.phase               = out_ph_r;
  assign out_ch.sample_index        = out_idx_r;
  assign out_ch.last_sample         = out_last_r;

  `TVP_ASSERT_IMP(a_done_issued, clk, rst_n, alu_done, iss_r)
  `TVP_ASSERT_NXT(a_plan_arms, clk, rst_n, (st_r == S_TD) && alu_done, active_r)
  `TVP_ASSERT_NXT(a_last_ends, clk, rst_n, out_load && last_r, !active_r)
  `TVP_ASSERT_IMP(a_phase_code, clk, rst_n, out_vld_r, out_ph_r != 2'd3)

endmodule
